// ===== rtl/core/sle_pkg.sv =====
// Shared definitions for the sequential list engine: field widths, command codes,
// status codes and the default capacity.
// No dependencies.
`default_nettype none

package sle_pkg;

	// Field widths of the request and result items.
	localparam int unsigned CMD_W  = 3;
	localparam int unsigned POS_W  = 9;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned LEN_W  = 9;

	// Packed stream widths, rounded up to whole bytes.
	localparam int unsigned IN_BITS  = CMD_W + POS_W + VAL_W;
	localparam int unsigned OUT_BITS = STAT_W + VAL_W + POS_W + LEN_W;
	localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int unsigned DEFAULT_CAPACITY = 256;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam cmd_t CMD_CLEAR   = 3'd0;
	localparam cmd_t CMD_INSERT  = 3'd1;
	localparam cmd_t CMD_DELETE  = 3'd2;
	localparam cmd_t CMD_LOCATE  = 3'd3;
	localparam cmd_t CMD_REVERSE = 3'd4;

	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_FULL     = 2'd1;
	localparam status_t STAT_BADPOS   = 2'd2;
	localparam status_t STAT_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/sle_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module sle_ram #(
	parameter  int unsigned WIDTH = 32,
	parameter  int unsigned DEPTH = 256,
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sequential_list_engine.sv =====
// Top level of the sequential list engine: command sequencer around one entry RAM.
// Depends on sle_pkg and sle_ram.
`default_nettype none

// Channel   Direction  Signals                      Contents (lowest bit first)
// s_*       in         s_tvalid s_tready s_tdata    cmd[2:0] position[11:3] item_value[43:12]
// m_*       out        m_tvalid m_tready m_tdata    status[1:0] removed_value[33:2]
//                                                   found_position[42:34] list_length[51:43]
//
// One command is worked on at a time; the entries live in a single RAM with one read
// and one write port, and each shifted, searched or swapped entry costs one RAM access.
// Insert and delete walk the entries from the given position to the end of the list,
// locate walks from the first entry to the first match or the end, and reverse swaps
// pairs inward from both ends; clear and rejected commands need no walk.
// Reset clears the count and the handshake state at once; the RAM needs no clearing
// pass, as only entries below the count are ever read.
// A finished result waits in the output register while the next item is accepted;
// only the delivery of that next result waits for the register to be emptied.

module sequential_list_engine #(
	parameter int unsigned CAPACITY = sle_pkg::DEFAULT_CAPACITY
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// cmd[2:0], position[11:3], item_value[43:12], zero padding above
	input  wire logic [sle_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// status[1:0], removed_value[33:2], found_position[42:34], list_length[51:43],
	// zero padding above
	output logic      [sle_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	import sle_pkg::*;

	// Address width of the store, width of the count, and a comparison width that
	// holds the count, a position and one more.
	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	// Sequencer states.
	localparam int unsigned SW = 4;
	localparam logic [SW-1:0] S_IDLE = 4'd0;
	localparam logic [SW-1:0] S_DEC  = 4'd1;
	localparam logic [SW-1:0] S_INS  = 4'd2;
	localparam logic [SW-1:0] S_INSW = 4'd3;
	localparam logic [SW-1:0] S_DEL  = 4'd4;
	localparam logic [SW-1:0] S_DELD = 4'd5;
	localparam logic [SW-1:0] S_LOC  = 4'd6;
	localparam logic [SW-1:0] S_LOCD = 4'd7;
	localparam logic [SW-1:0] S_RVA  = 4'd8;
	localparam logic [SW-1:0] S_RVB  = 4'd9;
	localparam logic [SW-1:0] S_RVC  = 4'd10;
	localparam logic [SW-1:0] S_RVD  = 4'd11;
	localparam logic [SW-1:0] S_FIN  = 4'd12;

	logic [SW-1:0]    state_q;
	logic [CW-1:0]    cnt_q;
	cmd_t             cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;

	// ptr_q walks the list; in a reverse it is the lower index and hi_q the upper one.
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    hi_q;
	logic [VAL_W-1:0] tmp_q;

	// Read pipeline stage: a read issued by a walk and the address it came from.
	logic             rd_vld_s1;
	logic             rd_first_s1;
	logic [AW-1:0]    rd_addr_s1;

	// Result being built, and the output register.
	status_t          res_status_q;
	logic [VAL_W-1:0] res_removed_q;
	logic [POS_W-1:0] res_found_q;
	logic             hit_q;

	logic             m_valid_q;
	status_t          out_status_q;
	logic [VAL_W-1:0] out_removed_q;
	logic [POS_W-1:0] out_found_q;
	logic [LEN_W-1:0] out_len_q;

	// RAM ports.
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	logic [CMPW-1:0]  cnt_w;
	logic [CMPW-1:0]  pos_w;
	logic [CMPW-1:0]  pos_m1_w;
	logic [CMPW-1:0]  last_w;
	logic [CMPW-1:0]  found_w;
	logic [AW-1:0]    pos_m1;
	logic [AW-1:0]    last_idx;
	logic [AW-1:0]    ptr_inc;
	logic [AW-1:0]    ptr_dec;
	logic [AW-1:0]    hi_dec;
	logic             pipe_rd;
	logic             loc_hit;
	logic             out_load;
	logic             accept;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);

	assign cnt_w    = CMPW'(cnt_q);
	assign pos_w    = CMPW'(pos_q);
	assign pos_m1_w = pos_w - CMPW'(1);
	assign last_w   = cnt_w - CMPW'(1);
	assign found_w  = CMPW'(rd_addr_s1) + CMPW'(1);
	assign pos_m1   = pos_m1_w[AW-1:0];
	assign last_idx = last_w[AW-1:0];
	assign ptr_inc  = ptr_q + AW'(1);
	assign ptr_dec  = ptr_q - AW'(1);
	assign hi_dec   = hi_q - AW'(1);

	// A locate compares the entry read in the previous cycle; only the first match counts.
	assign loc_hit  = rd_vld_s1 && (cmd_q == CMD_LOCATE) && (ram_rdata == val_q) && !hit_q;

	assign out_load = (state_q == S_FIN) && (!m_valid_q || m_tready);

	// Read port: the walks read at the pointer; a reverse reads both ends of a pair.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = ptr_q;
		case (state_q)
			S_INS, S_DEL, S_RVA: begin
				ram_re = 1'b1;
			end
			S_LOC: begin
				ram_re = !loc_hit;
			end
			S_RVB: begin
				ram_re    = 1'b1;
				ram_raddr = hi_q;
			end
			S_RVD: begin
				ram_re    = (ptr_inc < hi_dec);
				ram_raddr = ptr_inc;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	assign pipe_rd = ram_re && (state_q inside {S_INS, S_DEL, S_LOC});

	// Write port. The shift of an insert writes each entry one place up, that of a
	// delete one place down; the removed entry itself is only captured. Reads run ahead
	// of the writes in the direction of the walk, so no read meets a pending write.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1 + AW'(1);
		ram_wdata = ram_rdata;
		if (rd_vld_s1 && (cmd_q == CMD_INSERT)) begin
			ram_we = 1'b1;
		end else if (rd_vld_s1 && (cmd_q == CMD_DELETE) && !rd_first_s1) begin
			ram_we    = 1'b1;
			ram_waddr = rd_addr_s1 - AW'(1);
		end else if ((state_q == S_INSW) && !rd_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = pos_m1;
			ram_wdata = val_q;
		end else if (state_q == S_RVC) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q;
		end else if (state_q == S_RVD) begin
			ram_we    = 1'b1;
			ram_waddr = hi_q;
			ram_wdata = tmp_q;
		end
	end

	sle_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state: sequencer, count, read pipeline valid and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= pipe_rd;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					case (cmd_q)
						CMD_CLEAR: begin
							cnt_q   <= '0;
							state_q <= S_FIN;
						end
						CMD_INSERT: begin
							if (cnt_q == CW'(CAPACITY)) begin
								state_q <= S_FIN;
							end else if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
								state_q <= S_FIN;
							end else if (cnt_w >= pos_w) begin
								state_q <= S_INS;
							end else begin
								state_q <= S_INSW;
							end
						end
						CMD_DELETE: begin
							if (pos_w == '0 || pos_w > cnt_w) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_DEL;
							end
						end
						CMD_LOCATE: begin
							state_q <= (cnt_q == '0) ? S_FIN : S_LOC;
						end
						CMD_REVERSE: begin
							state_q <= (cnt_w >= CMPW'(2)) ? S_RVA : S_FIN;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_INS: begin
					if (ptr_q == pos_m1) begin
						state_q <= S_INSW;
					end
				end
				S_INSW: begin
					if (!rd_vld_s1) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_DEL: begin
					if (ptr_q == last_idx) begin
						state_q <= S_DELD;
					end
				end
				S_DELD: begin
					if (!rd_vld_s1) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_LOC: begin
					if (loc_hit || ptr_q == last_idx) begin
						state_q <= S_LOCD;
					end
				end
				S_LOCD: begin
					if (!rd_vld_s1) begin
						state_q <= S_FIN;
					end
				end
				S_RVA: begin
					state_q <= S_RVB;
				end
				S_RVB: begin
					state_q <= S_RVC;
				end
				S_RVC: begin
					state_q <= S_RVD;
				end
				S_RVD: begin
					state_q <= (ptr_inc < hi_dec) ? S_RVB : S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: request, pointers, result fields and output register.
	always_ff @(posedge clk) begin
		rd_addr_s1  <= ram_raddr;
		rd_first_s1 <= (state_q == S_DEL) && (ptr_q == pos_m1);

		if (accept) begin
			cmd_q <= s_tdata[CMD_W-1:0];
			pos_q <= s_tdata[CMD_W +: POS_W];
			val_q <= s_tdata[CMD_W+POS_W +: VAL_W];
		end

		if (rd_vld_s1 && rd_first_s1 && (cmd_q == CMD_DELETE)) begin
			res_removed_q <= ram_rdata;
		end

		if (loc_hit) begin
			hit_q       <= 1'b1;
			res_found_q <= found_w[POS_W-1:0];
		end

		case (state_q)
			S_DEC: begin
				res_removed_q <= '0;
				res_found_q   <= '0;
				hit_q         <= 1'b0;
				hi_q          <= last_idx;
				case (cmd_q)
					CMD_INSERT: begin
						ptr_q <= last_idx;
						if (cnt_q == CW'(CAPACITY)) begin
							res_status_q <= STAT_FULL;
						end else if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
							res_status_q <= STAT_BADPOS;
						end else begin
							res_status_q <= STAT_OK;
						end
					end
					CMD_DELETE: begin
						ptr_q <= pos_m1;
						if (pos_w == '0 || pos_w > cnt_w) begin
							res_status_q <= STAT_BADPOS;
						end else begin
							res_status_q <= STAT_OK;
						end
					end
					CMD_LOCATE: begin
						ptr_q        <= '0;
						res_status_q <= (cnt_q == '0) ? STAT_NOTFOUND : STAT_OK;
					end
					default: begin
						ptr_q        <= '0;
						res_status_q <= STAT_OK;
					end
				endcase
			end
			S_INS: begin
				ptr_q <= ptr_dec;
			end
			S_DEL: begin
				ptr_q <= ptr_inc;
			end
			S_LOC: begin
				if (!loc_hit) begin
					ptr_q <= ptr_inc;
				end
			end
			S_LOCD: begin
				if (!rd_vld_s1 && !hit_q) begin
					res_status_q <= STAT_NOTFOUND;
				end
			end
			S_RVB: begin
				tmp_q <= ram_rdata;
			end
			S_RVD: begin
				ptr_q <= ptr_inc;
				hi_q  <= hi_dec;
			end
			default: begin
				tmp_q <= tmp_q;
			end
		endcase

		if (out_load) begin
			out_status_q  <= res_status_q;
			out_removed_q <= res_removed_q;
			out_found_q   <= res_found_q;
			out_len_q     <= cnt_w[LEN_W-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), out_len_q, out_found_q,
	                   out_removed_q, out_status_q};

	// The count never passes the capacity.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("list count above capacity");

	// A read and a write in the same cycle never touch the same entry.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("read and write of the same entry in one cycle");

	// A walk read is only in flight while a walk or its drain is under way.
	a_pipe_state: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_INS || state_q == S_INSW || state_q == S_DEL ||
		               state_q == S_DELD || state_q == S_LOC || state_q == S_LOCD))
		else $error("walk read outside a walk");

	// No result is delivered while a command is still walking the store.
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !rd_vld_s1)
		else $error("result loaded with a read still in flight");

endmodule

`default_nettype wire

// ===== verif/list_result_checker.sv =====
// Result checker for the sequential list engine: keeps its own copy of the list, works out
// each command's outcome as it is accepted, and compares delivered results in order.
// Depends on sle_pkg.
`default_nettype none

module list_result_checker #(
	parameter int unsigned CAPACITY = sle_pkg::DEFAULT_CAPACITY
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	input  wire logic                               s_tready,
	// cmd, position, item_value, zero padding above
	input  wire logic [sle_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  wire logic                               m_tvalid,
	input  wire logic                               m_tready,
	// status, removed_value, found_position, list_length, zero padding above
	input  wire logic [sle_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output int                                      mismatches,
	output int                                      outstanding,
	output int                                      compared
);

	import sle_pkg::*;

	localparam int unsigned POS_LSB   = CMD_W;
	localparam int unsigned VAL_LSB   = CMD_W + POS_W;
	localparam int unsigned REM_LSB   = STAT_W;
	localparam int unsigned FOUND_LSB = STAT_W + VAL_W;
	localparam int unsigned LEN_LSB   = STAT_W + VAL_W + POS_W;
	localparam int unsigned MAX_LINES = 60;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   removed;
		logic [POS_W-1:0]   found;
		logic [LEN_W-1:0]   length;
	} list_outcome_t;

	logic [VAL_W-1:0] stored [CAPACITY];
	int               stored_len = 0;
	list_outcome_t    pending_outcomes [$];
	list_outcome_t    oldest;
	int               error_count = 0;
	int               result_count = 0;

	// Applies one command to the local list and returns the result it should produce.
	function automatic list_outcome_t list_outcome(input cmd_t cmd, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		list_outcome_t r;
		logic [VAL_W-1:0] swap;
		int k;
		int p;
		int lo;
		int hi;
		r = '0;
		r.status = STAT_OK;
		p = int'(pos);
		case (cmd)
			CMD_CLEAR: begin
				stored_len = 0;
			end
			CMD_INSERT: begin
				// A full list is reported ahead of any position error.
				if (stored_len >= CAPACITY) begin
					r.status = STAT_FULL;
				end else if (p < 1 || p > stored_len + 1) begin
					r.status = STAT_BADPOS;
				end else begin
					for (k = stored_len; k > p - 1; k--)
						stored[k] = stored[k-1];
					stored[p-1] = val;
					stored_len++;
				end
			end
			CMD_DELETE: begin
				if (p < 1 || p > stored_len) begin
					r.status = STAT_BADPOS;
				end else begin
					r.removed = stored[p-1];
					for (k = p; k < stored_len; k++)
						stored[k-1] = stored[k];
					stored_len--;
				end
			end
			CMD_LOCATE: begin
				for (k = 0; k < stored_len && r.found == 0; k++)
					if (stored[k] == val)
						r.found = POS_W'(k + 1);
				if (r.found == 0)
					r.status = STAT_NOTFOUND;
			end
			CMD_REVERSE: begin
				lo = 0;
				hi = stored_len - 1;
				while (lo < hi) begin
					swap = stored[lo];
					stored[lo] = stored[hi];
					stored[hi] = swap;
					lo++;
					hi--;
				end
			end
			default: begin
			end
		endcase
		r.length = LEN_W'(stored_len);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		error_count++;
		if (error_count <= MAX_LINES)
			$display("%0t: result %0d: %s is %0h, expected %0h", $time, result_count, what,
				got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_len = 0;
			pending_outcomes.delete();
		end else begin
			// Results are taken first: a result delivered at the same edge as a new command
			// always belongs to an earlier one.
			if (m_tvalid && m_tready) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[VAL_W-1:0], '0);
				end else begin
					oldest = pending_outcomes.pop_front();
					if (m_tdata[STAT_W-1:0] != oldest.status)
						report_mismatch("status", VAL_W'(m_tdata[STAT_W-1:0]),
							VAL_W'(oldest.status));
					if (m_tdata[REM_LSB +: VAL_W] != oldest.removed)
						report_mismatch("removed_value", m_tdata[REM_LSB +: VAL_W],
							oldest.removed);
					if (m_tdata[FOUND_LSB +: POS_W] != oldest.found)
						report_mismatch("found_position", VAL_W'(m_tdata[FOUND_LSB +: POS_W]),
							VAL_W'(oldest.found));
					if (m_tdata[LEN_LSB +: LEN_W] != oldest.length)
						report_mismatch("list_length", VAL_W'(m_tdata[LEN_LSB +: LEN_W]),
							VAL_W'(oldest.length));
				end
				result_count++;
			end
			if (s_tvalid && s_tready)
				pending_outcomes.push_back(list_outcome(s_tdata[CMD_W-1:0],
					s_tdata[POS_LSB +: POS_W], s_tdata[VAL_LSB +: VAL_W]));
		end
		outstanding <= pending_outcomes.size();
		mismatches  <= error_count;
		compared    <= result_count;
	end

endmodule

`default_nettype wire

// ===== verif/sequential_list_engine_test.sv =====
// Testbench top for the sequential list engine: clock, reset, command stimulus, result
// back-pressure, watchdog and verdict.
// Depends on sle_pkg, sequential_list_engine and list_result_checker.
`default_nettype none

module sequential_list_engine_test;

	import sle_pkg::*;

	localparam int unsigned CAP = DEFAULT_CAPACITY;

	// Command codes the block must ignore.
	localparam cmd_t CMD_UNUSED_FIRST = 3'd5;
	localparam cmd_t CMD_UNUSED_LAST  = 3'd7;

	// Number of commands after which the stimulus stops.
	localparam int ITEM_TARGET = 1400;

	// The long hold-off on the result side. The block keeps one finished result in its
	// output register and takes one more command, then has to stall its input.
	localparam int HOLD_CYCLES = 2000;

	// The slowest command is a reverse of a full list; add the long
	// hold-off and the worst sender gap and receiver stall, then allow several times that
	// before declaring the run hung.
	localparam int WATCHDOG_LIMIT = 20000;

	// Cycles allowed after the last result, so that a stray extra result would be seen.
	localparam int DRAIN_CYCLES = 600;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_PERIODIC
	} sink_mode_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int mismatches;
	int outstanding;
	int compared;

	// Stimulus bookkeeping. The list length is tracked only so that positions can be
	// chosen mostly in range; the checker owns the real prediction.
	int          list_len = 0;
	int          sent = 0;
	int          burst_left = 0;
	int          gap = 0;
	int          full_hits = 0;
	int          cmd_tally [8];
	logic [31:0] value_pool [16];

	// The result side reads this once, holds off for HOLD_CYCLES and then clears it.
	bit          hold_req = 1'b0;
	int          held_total = 0;

	sink_mode_t  sink_mode = SINK_OPEN;
	int          sink_left = 0;
	int          sink_phase = 0;
	int          held;

	int          quiet_cycles = 0;

	sequential_list_engine #(
		.CAPACITY (CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	list_result_checker #(
		.CAPACITY (CAP)
	) result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Values come mostly from a small pool, so that locates hit and duplicates occur;
	// the rest are fully random so that every bit of the value field moves.
	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 9) < 6)
			return value_pool[$urandom_range(0, 15)];
		return $urandom;
	endfunction

	// Offers one command and returns at the edge at which it is accepted. Bursts of random
	// length are separated by random gaps; some bursts are long and have no gap at all.
	task automatic issue(input cmd_t cmd, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(30, 80);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 6);
			end
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, val, pos, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		cmd_tally[cmd]++;
		case (cmd)
			CMD_CLEAR: begin
				list_len = 0;
			end
			CMD_INSERT: begin
				if (list_len < CAP && pos >= 1 && pos <= list_len + 1) begin
					list_len++;
					if (list_len == CAP)
						full_hits++;
				end
			end
			CMD_DELETE: begin
				if (pos >= 1 && pos <= list_len)
					list_len--;
			end
			default: begin
			end
		endcase
	endtask

	// General traffic with the list kept short to medium: inserts thin out once it grows,
	// a few positions are deliberately out of range, and unused codes turn up now and then.
	task automatic mixed_run(input int upto);
		int          roll;
		int          insert_share;
		int          span;
		cmd_t        cmd;
		logic [8:0]  pos;
		while (sent < upto) begin
			roll = $urandom_range(0, 99);
			insert_share = (list_len > 40) ? 25 : 42;
			if (roll < 2)
				cmd = CMD_CLEAR;
			else if (roll < insert_share)
				cmd = CMD_INSERT;
			else if (roll < 66)
				cmd = CMD_DELETE;
			else if (roll < 86)
				cmd = CMD_LOCATE;
			else if (roll < 94)
				cmd = CMD_REVERSE;
			else
				cmd = cmd_t'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
			pos = 9'($urandom_range(0, 511));
			if (cmd == CMD_INSERT || cmd == CMD_DELETE) begin
				span = (cmd == CMD_INSERT) ? list_len + 1 : list_len;
				roll = $urandom_range(0, 99);
				if (roll < 8)
					pos = ($urandom_range(0, 1) == 0) ? 9'd0 : 9'($urandom_range(span + 1, 511));
				else if (span == 0)
					pos = 9'd1;
				else if (cmd == CMD_INSERT && roll < 40)
					pos = 9'(span);
				else
					pos = 9'($urandom_range(1, span));
			end
			issue(cmd, pos, pick_value());
		end
	endtask

	// Grows the list to capacity, mostly by appending, then works the full list: inserts
	// that must report full whatever their position, a locate and a reverse over every
	// entry, deletes at both ends, and finally a clear.
	task automatic fill_to_capacity();
		while (list_len < CAP) begin
			if ($urandom_range(0, 3) == 0)
				issue(CMD_INSERT, 9'($urandom_range(1, list_len + 1)), pick_value());
			else
				issue(CMD_INSERT, 9'(list_len + 1), pick_value());
		end
		issue(CMD_INSERT, 9'd0, pick_value());
		issue(CMD_INSERT, 9'h1FF, pick_value());
		issue(CMD_INSERT, 9'd1, pick_value());
		issue(CMD_LOCATE, 9'($urandom), pick_value());
		issue(CMD_REVERSE, 9'($urandom), $urandom);
		issue(CMD_LOCATE, 9'($urandom), $urandom);
		issue(CMD_DELETE, 9'(CAP), $urandom);
		issue(CMD_DELETE, 9'(CAP), $urandom);
		issue(CMD_INSERT, 9'(CAP), pick_value());
		issue(CMD_DELETE, 9'd1, $urandom);
		repeat (4) issue(CMD_DELETE, 9'($urandom_range(1, list_len)), $urandom);
		issue(CMD_LOCATE, 9'($urandom), pick_value());
		issue(CMD_CLEAR, 9'($urandom), $urandom);
	endtask

	// Result side: a pattern of its own that changes mode at random intervals, with
	// one long hold-off when the stimulus asks for it.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(posedge clk);
				held_total = held_total + HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				if (sink_left == 0) begin
					sink_mode = sink_mode_t'($urandom_range(0, 3));
					sink_left = $urandom_range(20, 300);
				end
				sink_left--;
				sink_phase++;
				case (sink_mode)
					SINK_OPEN:     m_tready <= 1'b1;
					SINK_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
					SINK_SPARSE:   m_tready <= ($urandom_range(0, 5) == 0);
					SINK_PERIODIC: m_tready <= ((sink_phase % 8) < 3);
					default:       m_tready <= 1'b1;
				endcase
			end
		end
	end

	// Watchdog: any cycle with a transfer on either side counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, outstanding);
			$display("** sequential_list_engine: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		foreach (cmd_tally[i])
			cmd_tally[i] = 0;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'h0000_0001;
		value_pool[2] = 32'hFFFF_FFFF;
		value_pool[3] = 32'h7FFF_FFFF;
		value_pool[4] = 32'h8000_0000;
		for (int i = 5; i < 16; i++)
			value_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: operations on an empty list, positions just out of range and
		// at the top of the field, inserts at front, middle and end, a duplicate so that
		// locate must find the first match, reverses of one, odd and even lengths, and the
		// unused command codes.
		issue(CMD_LOCATE, 9'd0, 32'h0);
		issue(CMD_DELETE, 9'd1, 32'h0);
		issue(CMD_REVERSE, 9'd0, 32'h0);
		issue(CMD_INSERT, 9'd0, 32'h0000_0001);
		issue(CMD_INSERT, 9'd2, 32'h0000_0002);
		issue(CMD_INSERT, 9'd1, 32'h7FFF_FFFF);
		issue(CMD_REVERSE, 9'd0, 32'h0);
		issue(CMD_INSERT, 9'd1, 32'h8000_0000);
		issue(CMD_INSERT, 9'd3, 32'hFFFF_FFFF);
		issue(CMD_INSERT, 9'd2, 32'h0);
		issue(CMD_INSERT, 9'd1, 32'h0);
		issue(CMD_LOCATE, 9'd0, 32'h0);
		issue(CMD_LOCATE, 9'h1FF, 32'hFFFF_FFFF);
		issue(CMD_LOCATE, 9'd0, 32'h1234_5678);
		issue(CMD_REVERSE, 9'd0, 32'h0);
		issue(CMD_DELETE, 9'd0, 32'h0);
		issue(CMD_DELETE, 9'd6, 32'h0);
		issue(CMD_DELETE, 9'h1FF, 32'hFFFF_FFFF);
		issue(CMD_INSERT, 9'h1FF, 32'h5A5A_A5A5);
		issue(CMD_DELETE, 9'd5, 32'h0);
		issue(CMD_DELETE, 9'd1, 32'h0);
		issue(CMD_DELETE, 9'd2, 32'h0);
		issue(CMD_REVERSE, 9'h1FF, 32'hFFFF_FFFF);
		issue(CMD_UNUSED_FIRST, 9'h1FF, 32'hFFFF_FFFF);
		issue(CMD_UNUSED_LAST, 9'h0AA, 32'h0);
		issue(CMD_CLEAR, 9'h155, 32'hA5A5_5A5A);

		// Random part. The long hold-off is requested while the first full list is being
		// built, so that the sender keeps offering commands into a stalled block.
		mixed_run(330);
		hold_req = 1'b1;
		fill_to_capacity();
		mixed_run(900);
		fill_to_capacity();
		mixed_run(ITEM_TARGET);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands: %0d clear, %0d insert, %0d delete, ",
			sent, cmd_tally[CMD_CLEAR], cmd_tally[CMD_INSERT], cmd_tally[CMD_DELETE],
			"%0d locate, %0d reverse, %0d unused; %0d results compared.",
			cmd_tally[CMD_LOCATE], cmd_tally[CMD_REVERSE],
			cmd_tally[5] + cmd_tally[6] + cmd_tally[7], compared);
		$display("The list reached its capacity of %0d entries %0d times; ",
			CAP, full_hits,
			"results were held off for %0d cycles in one stretch.", held_total);
		if (mismatches == 0) begin
			$display("** sequential_list_engine: PASSED **");
		end else begin
			$display("** sequential_list_engine: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
